>>> rtl/core/grle_pkg.sv
// Package with the shared types, constants and gamma table of the LED pulse encoder.
`default_nettype none

package grle_pkg;

   localparam int GAMMA_ENTRIES_DEF = 512;
   localparam int ROM_SIZE          = 512;
   localparam int ROM_ADDR_W        = $clog2(ROM_SIZE);
   localparam int CHAN_W            = 16;
   localparam int LEVEL_W           = 8;
   localparam int WORD_W            = 3 * LEVEL_W;
   localparam int SYMBOLS           = WORD_W + 1;
   localparam int SYM_CNT_W         = $clog2(SYMBOLS);
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 16;

   localparam logic [7:0]  ZERO_HIGH_RST = 8'd6;
   localparam logic [7:0]  ONE_HIGH_RST  = 8'd15;
   localparam logic [7:0]  PERIOD_RST    = 8'd21;
   localparam logic [15:0] LATCH_RST     = 16'd825;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ZERO_HIGH = 2'd0,
      CSR_ONE_HIGH  = 2'd1,
      CSR_PERIOD    = 2'd2,
      CSR_LATCH     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } req_data_type;

   typedef struct packed {
      logic        data_bit;
      logic [7:0]  high_cycles;
      logic [15:0] low_cycles;
      logic        is_latch;
      logic        last;
   } rsp_data_type;

   typedef struct packed {
      logic [7:0]  zero_high_cycles;
      logic [7:0]  one_high_cycles;
      logic [7:0]  bit_period_cycles;
      logic [15:0] latch_cycles;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } levels_type;

   localparam logic [7:0] GAMMA_ROM [ROM_SIZE] = '{
      8'h00,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
      8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h02,8'h02,8'h02,8'h02,8'h02,
      8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h03,8'h03,8'h03,8'h03,8'h03,
      8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,
      8'h04,8'h04,8'h05,8'h05,8'h05,8'h05,8'h05,8'h05,8'h05,8'h05,8'h05,8'h06,8'h06,8'h06,8'h06,8'h06,
      8'h06,8'h06,8'h06,8'h06,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h08,8'h08,8'h08,8'h08,8'h08,
      8'h08,8'h08,8'h09,8'h09,8'h09,8'h09,8'h09,8'h09,8'h09,8'h0a,8'h0a,8'h0a,8'h0a,8'h0a,8'h0a,8'h0b,
      8'h0b,8'h0b,8'h0b,8'h0b,8'h0b,8'h0c,8'h0c,8'h0c,8'h0c,8'h0c,8'h0d,8'h0d,8'h0d,8'h0d,8'h0d,8'h0e,
      8'h0e,8'h0e,8'h0e,8'h0e,8'h0f,8'h0f,8'h0f,8'h0f,8'h0f,8'h10,8'h10,8'h10,8'h10,8'h10,8'h11,8'h11,
      8'h11,8'h11,8'h12,8'h12,8'h12,8'h12,8'h13,8'h13,8'h13,8'h13,8'h14,8'h14,8'h14,8'h14,8'h15,8'h15,
      8'h15,8'h15,8'h16,8'h16,8'h16,8'h16,8'h17,8'h17,8'h17,8'h17,8'h18,8'h18,8'h18,8'h19,8'h19,8'h19,
      8'h19,8'h1a,8'h1a,8'h1a,8'h1b,8'h1b,8'h1b,8'h1b,8'h1c,8'h1c,8'h1c,8'h1d,8'h1d,8'h1d,8'h1e,8'h1e,
      8'h1e,8'h1f,8'h1f,8'h1f,8'h20,8'h20,8'h20,8'h21,8'h21,8'h21,8'h22,8'h22,8'h22,8'h23,8'h23,8'h23,
      8'h24,8'h24,8'h24,8'h25,8'h25,8'h25,8'h26,8'h26,8'h26,8'h27,8'h27,8'h28,8'h28,8'h28,8'h29,8'h29,
      8'h29,8'h2a,8'h2a,8'h2b,8'h2b,8'h2b,8'h2c,8'h2c,8'h2d,8'h2d,8'h2d,8'h2e,8'h2e,8'h2f,8'h2f,8'h30,
      8'h30,8'h30,8'h31,8'h31,8'h32,8'h32,8'h33,8'h33,8'h33,8'h34,8'h34,8'h35,8'h35,8'h36,8'h36,8'h37,
      8'h37,8'h37,8'h38,8'h38,8'h39,8'h39,8'h3a,8'h3a,8'h3b,8'h3b,8'h3c,8'h3c,8'h3d,8'h3d,8'h3e,8'h3e,
      8'h3f,8'h3f,8'h40,8'h40,8'h41,8'h41,8'h42,8'h42,8'h43,8'h43,8'h44,8'h44,8'h45,8'h45,8'h46,8'h46,
      8'h47,8'h47,8'h48,8'h48,8'h49,8'h49,8'h4a,8'h4b,8'h4b,8'h4c,8'h4c,8'h4d,8'h4d,8'h4e,8'h4e,8'h4f,
      8'h50,8'h50,8'h51,8'h51,8'h52,8'h52,8'h53,8'h54,8'h54,8'h55,8'h55,8'h56,8'h57,8'h57,8'h58,8'h58,
      8'h59,8'h5a,8'h5a,8'h5b,8'h5b,8'h5c,8'h5d,8'h5d,8'h5e,8'h5f,8'h5f,8'h60,8'h60,8'h61,8'h62,8'h62,
      8'h63,8'h64,8'h64,8'h65,8'h66,8'h66,8'h67,8'h68,8'h68,8'h69,8'h6a,8'h6a,8'h6b,8'h6c,8'h6c,8'h6d,
      8'h6e,8'h6e,8'h6f,8'h70,8'h71,8'h71,8'h72,8'h73,8'h73,8'h74,8'h75,8'h76,8'h76,8'h77,8'h78,8'h78,
      8'h79,8'h7a,8'h7b,8'h7b,8'h7c,8'h7d,8'h7e,8'h7e,8'h7f,8'h80,8'h81,8'h81,8'h82,8'h83,8'h84,8'h84,
      8'h85,8'h86,8'h87,8'h88,8'h88,8'h89,8'h8a,8'h8b,8'h8c,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h90,8'h91,
      8'h92,8'h93,8'h94,8'h95,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'h9a,8'h9b,8'h9c,8'h9d,8'h9e,8'h9f,
      8'ha0,8'ha0,8'ha1,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,8'ha7,8'ha8,8'ha9,8'haa,8'hab,8'hac,8'had,
      8'hae,8'haf,8'hb0,8'hb0,8'hb1,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hbb,8'hbc,
      8'hbd,8'hbe,8'hbf,8'hc0,8'hc1,8'hc1,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hcb,
      8'hcc,8'hcd,8'hce,8'hcf,8'hd0,8'hd1,8'hd2,8'hd3,8'hd4,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,8'hdb,8'hdc,
      8'hdd,8'hde,8'hdf,8'he0,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he9,8'hea,8'heb,8'hec,8'hed,
      8'hee,8'hef,8'hf0,8'hf1,8'hf2,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa,8'hfb,8'hfd,8'hfe,8'hff
   };

endpackage

`default_nettype wire

>>> rtl/core/gamma_rgb_led_pulse_encoder.sv
// The first symbol of an item passes the lane level register, the serializer word register and the output register.
// One symbol per cycle while the output is not stalled, and 25 symbols per item.
// The serializer's symbol counter sets the symbol count; the lane stage holds the next item.
// Reset is synchronous and active high: it empties the pipeline and restores
// the timing registers to their default values.
`default_nettype none

module gamma_rgb_led_pulse_encoder
   import grle_pkg::*;
#(
   parameter int GAMMA_ENTRIES = GAMMA_ENTRIES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_data_type           req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_data_type                rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg_ff;
   levels_type levels;
   logic       lane_load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_high_cycles  <= ZERO_HIGH_RST;
         cfg_ff.one_high_cycles   <= ONE_HIGH_RST;
         cfg_ff.bit_period_cycles <= PERIOD_RST;
         cfg_ff.latch_cycles      <= LATCH_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_ZERO_HIGH: cfg_ff.zero_high_cycles  <= csr_wdata[7:0];
            CSR_ONE_HIGH:  cfg_ff.one_high_cycles   <= csr_wdata[7:0];
            CSR_PERIOD:    cfg_ff.bit_period_cycles <= csr_wdata[7:0];
            CSR_LATCH:     cfg_ff.latch_cycles      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   grle_lane #(.GAMMA_ENTRIES(GAMMA_ENTRIES)) u_lane_red (
      .clock (clock),
      .load  (lane_load),
      .value (req_data.red),
      .level (levels.red)
   );

   grle_lane #(.GAMMA_ENTRIES(GAMMA_ENTRIES)) u_lane_green (
      .clock (clock),
      .load  (lane_load),
      .value (req_data.green),
      .level (levels.green)
   );

   grle_lane #(.GAMMA_ENTRIES(GAMMA_ENTRIES)) u_lane_blue (
      .clock (clock),
      .load  (lane_load),
      .value (req_data.blue),
      .level (levels.blue)
   );

   grle_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .lane_load (lane_load),
      .levels    (levels),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/core/grle_lane.sv
// One color lane: scales a linear channel value to a table index and reads the gamma ROM.
`default_nettype none

module grle_lane
   import grle_pkg::*;
#(
   parameter int GAMMA_ENTRIES = GAMMA_ENTRIES_DEF
) (
   input  wire logic               clock,
   input  wire logic               load,
   input  wire logic [CHAN_W-1:0]  value,
   output logic      [LEVEL_W-1:0] level
);

   localparam int PROD_W = CHAN_W + $clog2(GAMMA_ENTRIES + 1);

   logic [PROD_W-1:0]        product;
   logic [PROD_W-CHAN_W-1:0] index;
   logic [ROM_ADDR_W-1:0]    rom_addr;
   logic [LEVEL_W-1:0]       level_ff;

   assign product  = PROD_W'(value) * PROD_W'(GAMMA_ENTRIES);
   assign index    = product[PROD_W-1:CHAN_W];
   assign rom_addr = (index >= ROM_SIZE) ? ROM_ADDR_W'(ROM_SIZE - 1) : ROM_ADDR_W'(index);

   always_ff @(posedge clock) begin
      if (load) begin
         level_ff <= GAMMA_ROM[rom_addr];
      end
   end

   assign level = level_ff;

endmodule

`default_nettype wire

>>> rtl/core/grle_serializer.sv
// Merges the three lane levels into one color word and emits its pulse symbols.
`default_nettype none

module grle_serializer
   import grle_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   output logic              lane_load,
   input  wire levels_type   levels,
   input  wire cfg_type      cfg,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_data_type      rsp_data
);

   localparam logic [SYM_CNT_W-1:0] LATCH_SLOT = SYM_CNT_W'(SYMBOLS - 1);

   logic                 lane_valid_ff, lane_valid_in;
   logic                 busy_ff, busy_in;
   logic [SYM_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_data_type         rsp_data_ff, rsp_data_in;

   logic       advance;
   logic       fire;
   logic       at_latch;
   logic       load;
   logic       bit_now;
   logic [7:0] high_now;

   always_comb begin
      advance   = !rsp_valid_ff || !rsp_stall;
      fire      = busy_ff && advance;
      at_latch  = (cnt_ff == LATCH_SLOT);
      load      = lane_valid_ff && (!busy_ff || (fire && at_latch));
      req_stall = lane_valid_ff && !load;
      lane_load = req_valid && !req_stall;

      lane_valid_in = lane_load ? 1'b1 : (load ? 1'b0 : lane_valid_ff);

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      word_in = word_ff;
      if (load) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         word_in = {levels.green, levels.red, levels.blue};
      end else if (fire) begin
         busy_in = !at_latch;
         cnt_in  = cnt_ff + 1'b1;
         word_in = {word_ff[WORD_W-2:0], 1'b0};
      end

      bit_now  = word_ff[WORD_W-1];
      high_now = bit_now ? cfg.one_high_cycles : cfg.zero_high_cycles;

      if (at_latch) begin
         rsp_data_in.data_bit    = 1'b0;
         rsp_data_in.high_cycles = '0;
         rsp_data_in.low_cycles  = cfg.latch_cycles;
         rsp_data_in.is_latch    = 1'b1;
         rsp_data_in.last        = 1'b1;
      end else begin
         rsp_data_in.data_bit    = bit_now;
         rsp_data_in.high_cycles = high_now;
         rsp_data_in.low_cycles  = (cfg.bit_period_cycles > high_now) ?
                                   16'(cfg.bit_period_cycles - high_now) : 16'd0;
         rsp_data_in.is_latch    = 1'b0;
         rsp_data_in.last        = 1'b0;
      end

      rsp_valid_in = fire ? 1'b1 : (advance ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
         busy_ff       <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         lane_valid_ff <= lane_valid_in;
         busy_ff       <= busy_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/grle_checker.sv
// Port-level checker for the LED pulse encoder and its bind to the top level.
`default_nettype none

module grle_checker
   import grle_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire req_data_type           req_data,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire rsp_data_type           rsp_data,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic                 req_take;
   logic                 rsp_take;
   logic [SYM_CNT_W-1:0] sym_cnt_ff, sym_cnt_in;
   logic [3:0]           pending_ff, pending_in;
   logic                 unused_inputs;

   assign req_take      = req_valid && !req_stall;
   assign rsp_take      = rsp_valid && !rsp_stall;
   assign unused_inputs = ^{req_data, csr_valid, csr_ready, csr_index, csr_wdata};

   always_comb begin
      sym_cnt_in = sym_cnt_ff;
      if (rsp_take) begin
         sym_cnt_in = rsp_data.last ? '0 : sym_cnt_ff + 1'b1;
      end
      pending_in = pending_ff + 4'(req_take) - 4'(rsp_take && rsp_data.last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_cnt_ff <= '0;
         pending_ff <= '0;
      end else begin
         sym_cnt_ff <= sym_cnt_in;
         pending_ff <= pending_in;
      end
   end

   property p_stall_holds;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data);
   endproperty
   a_stall_holds: assert property (p_stall_holds)
      else $error("Stalled result item changed or was dropped.");

   property p_latch_slot;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_data.is_latch == (sym_cnt_ff == SYM_CNT_W'(SYMBOLS - 1)));
   endproperty
   a_latch_slot: assert property (p_latch_slot)
      else $error("Latch item is not the final item of its color.");

   property p_no_orphan;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (pending_ff != 4'd0 || unused_inputs != unused_inputs);
   endproperty
   a_no_orphan: assert property (p_no_orphan)
      else $error("Result item shown with no color item outstanding.");

   property p_reset_empty;
      @(posedge clock) !reset && $past(reset) |-> !rsp_valid;
   endproperty
   a_reset_empty: assert property (p_reset_empty)
      else $error("Result item shown right after reset.");

endmodule

bind gamma_rgb_led_pulse_encoder grle_checker u_grle_checker (.*);

`default_nettype wire

>>> dv/tb_top.sv
// Testbench for the gamma-corrected RGB to LED pulse-symbol encoder with its own predictor.
`timescale 1ns / 100ps

module tb_top;
   import grle_pkg::*;

   localparam int SYMBOLS_PER_COLOR = 25;
   localparam int PHASES            = 8;
   localparam int ITEMS_PER_PHASE   = 12;
   localparam int LONG_HOLD         = 400;
   localparam int DRAIN_CYCLES      = 30;
   localparam int CYCLE_LIMIT       = 200000;

   localparam cfg_type TIMING_RST = '{8'd6, 8'd15, 8'd21, 16'd825};

   typedef struct {
      req_data_type color;
      bit           typed;
      logic [23:0]  levels;
   } color_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_data_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_data_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_ZERO_HIGH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rsp_data_type pending_symbols [$];
   cfg_type timing = TIMING_RST;
   int mismatches = 0;
   int cycle_count = 0;
   bit long_hold = 1'b0;

   logic [7:0] gamma_tab [0:511] = '{
      'h00,'h01,'h01,'h01,'h01,'h01,'h01,'h01,'h01,'h01,'h01,'h01,'h01,'h01,'h01,'h01,
      'h01,'h01,'h01,'h01,'h01,'h01,'h01,'h01,'h01,'h01,'h01,'h02,'h02,'h02,'h02,'h02,
      'h02,'h02,'h02,'h02,'h02,'h02,'h02,'h02,'h02,'h02,'h02,'h03,'h03,'h03,'h03,'h03,
      'h03,'h03,'h03,'h03,'h03,'h03,'h03,'h03,'h04,'h04,'h04,'h04,'h04,'h04,'h04,'h04,
      'h04,'h04,'h05,'h05,'h05,'h05,'h05,'h05,'h05,'h05,'h05,'h06,'h06,'h06,'h06,'h06,
      'h06,'h06,'h06,'h06,'h07,'h07,'h07,'h07,'h07,'h07,'h07,'h08,'h08,'h08,'h08,'h08,
      'h08,'h08,'h09,'h09,'h09,'h09,'h09,'h09,'h09,'h0a,'h0a,'h0a,'h0a,'h0a,'h0a,'h0b,
      'h0b,'h0b,'h0b,'h0b,'h0b,'h0c,'h0c,'h0c,'h0c,'h0c,'h0d,'h0d,'h0d,'h0d,'h0d,'h0e,
      'h0e,'h0e,'h0e,'h0e,'h0f,'h0f,'h0f,'h0f,'h0f,'h10,'h10,'h10,'h10,'h10,'h11,'h11,
      'h11,'h11,'h12,'h12,'h12,'h12,'h13,'h13,'h13,'h13,'h14,'h14,'h14,'h14,'h15,'h15,
      'h15,'h15,'h16,'h16,'h16,'h16,'h17,'h17,'h17,'h17,'h18,'h18,'h18,'h19,'h19,'h19,
      'h19,'h1a,'h1a,'h1a,'h1b,'h1b,'h1b,'h1b,'h1c,'h1c,'h1c,'h1d,'h1d,'h1d,'h1e,'h1e,
      'h1e,'h1f,'h1f,'h1f,'h20,'h20,'h20,'h21,'h21,'h21,'h22,'h22,'h22,'h23,'h23,'h23,
      'h24,'h24,'h24,'h25,'h25,'h25,'h26,'h26,'h26,'h27,'h27,'h28,'h28,'h28,'h29,'h29,
      'h29,'h2a,'h2a,'h2b,'h2b,'h2b,'h2c,'h2c,'h2d,'h2d,'h2d,'h2e,'h2e,'h2f,'h2f,'h30,
      'h30,'h30,'h31,'h31,'h32,'h32,'h33,'h33,'h33,'h34,'h34,'h35,'h35,'h36,'h36,'h37,
      'h37,'h37,'h38,'h38,'h39,'h39,'h3a,'h3a,'h3b,'h3b,'h3c,'h3c,'h3d,'h3d,'h3e,'h3e,
      'h3f,'h3f,'h40,'h40,'h41,'h41,'h42,'h42,'h43,'h43,'h44,'h44,'h45,'h45,'h46,'h46,
      'h47,'h47,'h48,'h48,'h49,'h49,'h4a,'h4b,'h4b,'h4c,'h4c,'h4d,'h4d,'h4e,'h4e,'h4f,
      'h50,'h50,'h51,'h51,'h52,'h52,'h53,'h54,'h54,'h55,'h55,'h56,'h57,'h57,'h58,'h58,
      'h59,'h5a,'h5a,'h5b,'h5b,'h5c,'h5d,'h5d,'h5e,'h5f,'h5f,'h60,'h60,'h61,'h62,'h62,
      'h63,'h64,'h64,'h65,'h66,'h66,'h67,'h68,'h68,'h69,'h6a,'h6a,'h6b,'h6c,'h6c,'h6d,
      'h6e,'h6e,'h6f,'h70,'h71,'h71,'h72,'h73,'h73,'h74,'h75,'h76,'h76,'h77,'h78,'h78,
      'h79,'h7a,'h7b,'h7b,'h7c,'h7d,'h7e,'h7e,'h7f,'h80,'h81,'h81,'h82,'h83,'h84,'h84,
      'h85,'h86,'h87,'h88,'h88,'h89,'h8a,'h8b,'h8c,'h8c,'h8d,'h8e,'h8f,'h90,'h90,'h91,
      'h92,'h93,'h94,'h95,'h95,'h96,'h97,'h98,'h99,'h9a,'h9a,'h9b,'h9c,'h9d,'h9e,'h9f,
      'ha0,'ha0,'ha1,'ha2,'ha3,'ha4,'ha5,'ha6,'ha7,'ha7,'ha8,'ha9,'haa,'hab,'hac,'had,
      'hae,'haf,'hb0,'hb0,'hb1,'hb2,'hb3,'hb4,'hb5,'hb6,'hb7,'hb8,'hb9,'hba,'hbb,'hbc,
      'hbd,'hbe,'hbf,'hc0,'hc1,'hc1,'hc2,'hc3,'hc4,'hc5,'hc6,'hc7,'hc8,'hc9,'hca,'hcb,
      'hcc,'hcd,'hce,'hcf,'hd0,'hd1,'hd2,'hd3,'hd4,'hd6,'hd7,'hd8,'hd9,'hda,'hdb,'hdc,
      'hdd,'hde,'hdf,'he0,'he1,'he2,'he3,'he4,'he5,'he6,'he7,'he9,'hea,'heb,'hec,'hed,
      'hee,'hef,'hf0,'hf1,'hf2,'hf4,'hf5,'hf6,'hf7,'hf8,'hf9,'hfa,'hfb,'hfd,'hfe,'hff
   };

   color_row_type directed_rows [12] = '{
      '{'{16'h0000, 16'h0000, 16'h0000}, 1'b1, 24'h000000},
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, 24'hFFFFFF},
      '{'{16'h0000, 16'hFFFF, 16'h0000}, 1'b1, 24'hFF0000},
      '{'{16'hFFFF, 16'h0000, 16'h0000}, 1'b1, 24'h00FF00},
      '{'{16'h0000, 16'h0000, 16'hFFFF}, 1'b1, 24'h0000FF},
      '{'{16'h007F, 16'h007F, 16'h007F}, 1'b1, 24'h000000},
      '{'{16'h0080, 16'h0080, 16'h0080}, 1'b1, 24'h010101},
      '{'{16'hFF7F, 16'hFF7F, 16'hFF7F}, 1'b1, 24'hFEFEFE},
      '{'{16'h8000, 16'h4000, 16'h2000}, 1'b0, 24'h000000},
      '{'{16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, 24'h000000},
      '{'{16'h5555, 16'hAAAA, 16'h5555}, 1'b0, 24'h000000},
      '{'{16'h1234, 16'hFEDC, 16'h0100}, 1'b0, 24'h000000}
   };

   // Zero-high and high-above-period settings exercise the saturating low time.
   cfg_type timing_settings [5] = '{
      '{8'd1,   8'd255, 8'd255, 16'd65535},
      '{8'd1,   8'd1,   8'd2,   16'd1},
      '{8'd200, 8'd255, 8'd2,   16'd16},
      '{8'd0,   8'd0,   8'd0,   16'd0},
      '{8'd255, 8'd1,   8'd128, 16'd300}
   };

   gamma_rgb_led_pulse_encoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [23:0] gamma_levels(req_data_type color);
      return {gamma_tab[color.green[15:7]], gamma_tab[color.red[15:7]],
              gamma_tab[color.blue[15:7]]};
   endfunction

   task automatic queue_symbols(logic [23:0] levels, cfg_type t);
      rsp_data_type sym;
      logic [7:0] high;
      for (int k = 23; k >= 0; k--) begin
         high = levels[k] ? t.one_high_cycles : t.zero_high_cycles;
         sym.data_bit = levels[k];
         sym.high_cycles = high;
         sym.low_cycles = (t.bit_period_cycles > high) ?
                          {8'd0, t.bit_period_cycles - high} : 16'd0;
         sym.is_latch = 1'b0;
         sym.last = 1'b0;
         pending_symbols.push_back(sym);
      end
      sym.data_bit = 1'b0;
      sym.high_cycles = 8'd0;
      sym.low_cycles = t.latch_cycles;
      sym.is_latch = 1'b1;
      sym.last = 1'b1;
      pending_symbols.push_back(sym);
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic program_timing(cfg_type t);
      csr_index_type idx;
      idx = CSR_ZERO_HIGH;
      csr_valid <= 1'b1;
      repeat (4) begin
         csr_index <= idx;
         case (idx)
            CSR_ZERO_HIGH: csr_wdata <= {8'($urandom), t.zero_high_cycles};
            CSR_ONE_HIGH:  csr_wdata <= {8'($urandom), t.one_high_cycles};
            CSR_PERIOD:    csr_wdata <= {8'($urandom), t.bit_period_cycles};
            CSR_LATCH:     csr_wdata <= t.latch_cycles;
            default:       csr_wdata <= '0;
         endcase
         do @(posedge clock); while (!csr_ready);
         idx = idx.next();
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send_color(req_data_type color, bit typed, logic [23:0] levels, int gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= color;
      do @(posedge clock); while (req_stall);
      if (typed) begin
         queue_symbols(levels, TIMING_RST);
      end else begin
         queue_symbols(gamma_levels(color), timing);
      end
   endtask

   task automatic wait_idle();
      while (pending_symbols.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] random_channel();
      case ($urandom_range(0, 4))
         0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         1:       return 16'($urandom_range(0, 255));
         2:       return {9'($urandom), $urandom_range(0, 1) ? 7'h7F : 7'h00};
         default: return 16'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_data_type want;
      if (reset) begin
         timing = TIMING_RST;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ZERO_HIGH: timing.zero_high_cycles = csr_wdata[7:0];
               CSR_ONE_HIGH:  timing.one_high_cycles = csr_wdata[7:0];
               CSR_PERIOD:    timing.bit_period_cycles = csr_wdata[7:0];
               CSR_LATCH:     timing.latch_cycles = csr_wdata;
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_symbols.size() == 0) begin
               $display("%0t: unexpected symbol, expected none actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = pending_symbols.pop_front();
               check_field("data_bit", want.data_bit, rsp_data.data_bit);
               check_field("high_cycles", want.high_cycles, rsp_data.high_cycles);
               check_field("low_cycles", want.low_cycles, rsp_data.low_cycles);
               check_field("is_latch", want.is_latch, rsp_data.is_latch);
               check_field("last", want.last, rsp_data.last);
            end
         end
      end
   end

   initial begin : rsp_side
      int gap;
      int taken;
      bit held_off;
      bit steady;
      taken = 0;
      held_off = 1'b0;
      steady = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % SYMBOLS_PER_COLOR == 0) begin
            steady = ($urandom_range(0, 3) == 0);
         end
         if (long_hold && !held_off) begin
            rsp_stall <= 1'b1;
            for (int n = 0; n < LONG_HOLD; n++) @(posedge clock);
            held_off = 1'b1;
         end
         gap = steady ? 0 : $urandom_range(0, 14);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : req_side
      req_data_type color;
      cfg_type setting;
      bit steady;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      steady = 1'b0;
      foreach (directed_rows[i]) begin
         send_color(directed_rows[i].color, directed_rows[i].typed,
                    directed_rows[i].levels, $urandom_range(0, 14));
      end
      req_valid <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         if (p < 5) begin
            setting = timing_settings[p];
         end else begin
            setting = '{8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom)};
         end
         program_timing(setting);
         // The first phase runs back to back into a long output stall.
         if (p == 0) begin
            long_hold = 1'b1;
         end
         steady = (p == 0) || ($urandom_range(0, 2) == 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            color.red = random_channel();
            color.green = random_channel();
            color.blue = random_channel();
            send_color(color, 1'b0, 24'd0, steady ? 0 : $urandom_range(0, 14));
         end
         req_valid <= 1'b0;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
